// File: hw/rtl/epoch_seconds_to_date_assert.svh
// Assertion macros for the epoch_seconds_to_date checker.
`ifndef EPOCH_SECONDS_TO_DATE_ASSERT_SVH
`define EPOCH_SECONDS_TO_DATE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ESD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("epoch_seconds_to_date assertion failed");

// Next-cycle implication, disabled during reset.
`define ESD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("epoch_seconds_to_date assertion failed");

`endif

// File: hw/rtl/esd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_pkg
// Types, constants and the month-length table for the date converter.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam int SECS_W  = 31;
    localparam int DAYS_W  = 15;
    localparam int YEAR_W  = 11;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    // secs / 86400 = ((secs >> 7) * DAY_RECIP) >> 34, exact for secs < 2^31
    localparam int DIV_PRE_SHIFT = 7;
    localparam int RECIP_W       = 25;
    localparam int PROD_W        = SECS_W - DIV_PRE_SHIFT + RECIP_W;
    localparam int DAY_SHIFT     = 34;

    localparam logic [RECIP_W-1:0] DAY_RECIP  = 25'd25451659;
    localparam logic [YEAR_W-1:0]  EPOCH_YEAR = 11'd1970;
    localparam logic [1:0]         EPOCH_MOD4   = 2'(1970 % 4);
    localparam logic [6:0]         EPOCH_MOD100 = 7'(1970 % 100);
    localparam logic [8:0]         EPOCH_MOD400 = 9'(1970 % 400);
    localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_esd_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic year_step;
        logic month_step;
        logic out_load;
    } t_esd_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_esd_sts;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// File: hw/rtl/esd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_ctrl
// Sequencer: division, year walk, month walk, then hand-off to output.
// ----------------------------------------------------------------------------
module esd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    input  esd_pkg::t_esd_sts i_sts,
    output esd_pkg::t_esd_cmd o_cmd
);
    import esd_pkg::*;

    t_esd_state r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_YEAR;
            end
            S_YEAR: begin
                if (i_sts.year_done) begin
                    n_state = S_MONTH;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            S_MONTH: begin
                if (i_sts.month_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;

endmodule

// File: hw/rtl/esd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_dp
// Datapath: reciprocal divide by 86400, year and month subtraction, output reg.
// ----------------------------------------------------------------------------
module esd_dp (
    input  logic                           i_clk,
    input  esd_pkg::t_esd_cmd              i_cmd,
    input  logic [esd_pkg::SECS_W-1:0]     i_secs,
    output esd_pkg::t_esd_sts              o_sts,
    output logic [esd_pkg::YEAR_W-1:0]     o_year,
    output logic [esd_pkg::MONTH_W-1:0]    o_month,
    output logic [esd_pkg::DAY_W-1:0]      o_day
);
    import esd_pkg::*;

    logic [SECS_W-DIV_PRE_SHIFT-1:0] r_rem;
    logic [DAYS_W-1:0]  r_days;
    logic [YEAR_W-1:0]  r_year;
    logic [1:0]         r_mod4;
    logic [6:0]         r_mod100;
    logic [8:0]         r_mod400;
    logic [MONTH_W-1:0] r_month;
    logic [YEAR_W-1:0]  r_year_o;
    logic [MONTH_W-1:0] r_month_o;
    logic [DAY_W-1:0]   r_day_o;

    logic [PROD_W-1:0] w_prod;
    logic              w_leap;
    logic [8:0]        w_ylen;
    logic [DAY_W-1:0]  w_mlen;

    assign w_prod = PROD_W'(r_rem) * PROD_W'(DAY_RECIP);
    assign w_leap = (r_mod400 == 9'd0) || ((r_mod4 == 2'd0) && (r_mod100 != 7'd0));
    assign w_ylen = w_leap ? 9'd366 : 9'd365;
    assign w_mlen = month_len(r_month, w_leap);

    assign o_sts.year_done  = (r_days < DAYS_W'(w_ylen));
    assign o_sts.month_done = (r_month == LAST_MONTH) || (r_days < DAYS_W'(w_mlen));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem    <= i_secs[SECS_W-1:DIV_PRE_SHIFT];
            r_days   <= '0;
            r_year   <= EPOCH_YEAR;
            r_mod4   <= EPOCH_MOD4;
            r_mod100 <= EPOCH_MOD100;
            r_mod400 <= EPOCH_MOD400;
            r_month  <= MONTH_W'(1);
        end else if (i_cmd.div_step) begin
            r_days <= w_prod[DAY_SHIFT +: DAYS_W];
        end else if (i_cmd.year_step) begin
            r_days   <= r_days - DAYS_W'(w_ylen);
            r_year   <= r_year + YEAR_W'(1);
            r_mod4   <= r_mod4 + 2'd1;
            r_mod100 <= (r_mod100 == 7'd99) ? 7'd0 : r_mod100 + 7'd1;
            r_mod400 <= (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 9'd1;
        end else if (i_cmd.month_step) begin
            r_days  <= r_days - DAYS_W'(w_mlen);
            r_month <= r_month + MONTH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_year_o  <= r_year;
            r_month_o <= r_month;
            r_day_o   <= r_days[DAY_W-1:0] + DAY_W'(1);
        end
    end

    assign o_year  = r_year_o;
    assign o_month = r_month_o;
    assign o_day   = r_day_o;

endmodule

// File: hw/rtl/epoch_seconds_to_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_date
// Seconds since 1970-01-01 to Gregorian year, month and day of month.
// The year walk covers Y whole years (0..68) and the month walk M whole
// months (0..11), Y + M at most 78; the divide is a single multiply in S_DIV.
// A new input is taken only in idle, after the last result is loaded into
// the output register; the year and month walks step one per cycle.
// Reset: synchronous active low; returns the sequencer to idle, no output.
// ----------------------------------------------------------------------------
module epoch_seconds_to_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [30:0] elapsed_seconds, [31] pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // [10:0] year_out, [14:11] month_out,
                                         // [19:15] day_out, [23:20] pad
);
    import esd_pkg::*;

    t_esd_cmd           w_cmd;
    t_esd_sts           w_sts;
    logic [YEAR_W-1:0]  w_year;
    logic [MONTH_W-1:0] w_month;
    logic [DAY_W-1:0]   w_day;

    esd_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    esd_dp u_dp (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_secs  (i_s_axis_tdata[SECS_W-1:0]),
        .o_sts   (w_sts),
        .o_year  (w_year),
        .o_month (w_month),
        .o_day   (w_day)
    );

    assign o_m_axis_tdata = {4'b0000, w_day, w_month, w_year};

endmodule

// File: hw/rtl/esd_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_chk
// Port-level checks for epoch_seconds_to_date, bound to the top level.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_date_assert.svh"

module esd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata
);

    // one conversion at a time: busy right after an input transfer
    `ESD_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // stalled result holds
    `ESD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    `ESD_ASSERT_NOW(a_month_range, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tdata[14:11] >= 4'd1) && (o_m_axis_tdata[14:11] <= 4'd12))

    `ESD_ASSERT_NOW(a_date_range, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tdata[19:15] != 5'd0) && (o_m_axis_tdata[10:0] >= 11'd1970) && (o_m_axis_tdata[10:0] <= 11'd2038))

endmodule

bind epoch_seconds_to_date esd_chk u_esd_chk (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for epoch_seconds_to_date. A table of directed second
// counts (epoch, day and year edges, leap days, the top of the 31-bit range)
// is followed by random counts. Each transfer out is checked against the date
// from the table or a calendar predictor. Both stream sides idle at random,
// and the receiver holds off once for a long stretch to stall the input side.
// ----------------------------------------------------------------------------
module testbench;

    import esd_pkg::*;

    localparam int  RANDOM_ITEMS   = 600;
    localparam int  DIRECTED_ROWS  = 16;
    localparam int  HOLD_RESULT    = 120;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  DRAIN_CYCLES   = 120;
    localparam int  STALL_LIMIT    = 5000;
    localparam int  SECS_PER_DAY   = 86400;
    localparam int  LAST_DAY_INDEX = 24855;
    localparam longint MAX_SECS    = 64'd2147483647;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_cal_date;

    typedef struct packed {
        logic [SECS_W-1:0]  secs;
        logic               typed;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // [30:0] elapsed_seconds, [31] pad
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;        // [10:0] year_out, [14:11] month_out,
                                        // [19:15] day_out, [23:20] pad

    t_cal_date expected_dates[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        dates_checked = 0;
    int        leap_days_seen = 0;
    int        newest_year = 0;

    // Rows with typed = 1 carry their date; the others go to the predictor.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{31'd0,            1'b1, 11'd1970, 4'd1, 5'd1},
        '{31'd1,            1'b1, 11'd1970, 4'd1, 5'd1},
        '{31'd86399,        1'b1, 11'd1970, 4'd1, 5'd1},
        '{31'd86400,        1'b0, 11'd0,    4'd0, 5'd0},
        '{31'd2678399,      1'b0, 11'd0,    4'd0, 5'd0},
        '{31'd31535999,     1'b0, 11'd0,    4'd0, 5'd0},
        '{31'd31536000,     1'b0, 11'd0,    4'd0, 5'd0},
        '{31'd68169600,     1'b0, 11'd0,    4'd0, 5'd0},
        '{31'd94694399,     1'b0, 11'd0,    4'd0, 5'd0},
        '{31'd951782400,    1'b0, 11'd0,    4'd0, 5'd0},
        '{31'd978220800,    1'b0, 11'd0,    4'd0, 5'd0},
        '{31'd978307200,    1'b0, 11'd0,    4'd0, 5'd0},
        '{31'h4000_0000,    1'b0, 11'd0,    4'd0, 5'd0},
        '{31'h5555_5555,    1'b0, 11'd0,    4'd0, 5'd0},
        '{31'h2AAA_AAAA,    1'b0, 11'd0,    4'd0, 5'd0},
        '{31'h7FFF_FFFF,    1'b1, 11'd2038, 4'd1, 5'd19}
    };

    epoch_seconds_to_date DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit is_leap(input int unsigned yr);
        return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    endfunction

    function automatic t_cal_date date_of_seconds(input logic [SECS_W-1:0] secs);
        int unsigned days_left;
        int unsigned yr;
        int unsigned mon;
        int unsigned span;
        t_cal_date   d;
        days_left = 32'(secs) / SECS_PER_DAY;
        yr = 1970;
        forever begin
            span = is_leap(yr) ? 366 : 365;
            if (days_left < span) break;
            days_left -= span;
            yr++;
        end
        mon = 1;
        while (mon < 12) begin
            case (mon)
                2:           span = is_leap(yr) ? 29 : 28;
                4, 6, 9, 11: span = 30;
                default:     span = 31;
            endcase
            if (days_left < span) break;
            days_left -= span;
            mon++;
        end
        d.year  = YEAR_W'(yr);
        d.month = MONTH_W'(mon);
        d.day   = DAY_W'(days_left + 1);
        return d;
    endfunction

    // Bursts of back-to-back traffic alternate with randomly idled stretches.
    function automatic int draw_gap(input int n);
        if ((n / 32) % 3 == 0) begin
            return 0;
        end
        return int'($urandom_range(0, 15));
    endfunction

    function automatic logic [SECS_W-1:0] random_seconds();
        longint secs;
        int     pick;
        pick = int'($urandom_range(0, 9));
        if (pick <= 3) begin
            secs = longint'($urandom() & 32'h7FFF_FFFF);
        end else if (pick <= 6) begin
            secs = longint'($urandom_range(0, LAST_DAY_INDEX)) * SECS_PER_DAY;
            case ($urandom_range(0, 2))
                0:       secs += 0;
                1:       secs += SECS_PER_DAY - 1;
                default: secs += longint'($urandom_range(0, SECS_PER_DAY - 1));
            endcase
            if (secs > MAX_SECS) begin
                secs = MAX_SECS - longint'($urandom_range(0, 11647));
            end
        end else if (pick <= 8) begin
            secs = longint'($urandom_range(0, 3 * 365 * SECS_PER_DAY));
        end else begin
            secs = MAX_SECS - longint'($urandom_range(0, 40 * SECS_PER_DAY));
        end
        return SECS_W'(secs);
    endfunction

    task automatic send_seconds(input logic [SECS_W-1:0] secs, input bit typed,
                                input t_cal_date want);
        int        gap;
        t_cal_date entry;
        gap = draw_gap(items_sent);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, secs};
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        entry = typed ? want : date_of_seconds(secs);
        expected_dates = {expected_dates, entry};
        items_sent++;
    endtask

    // Result side: random hold-offs, one long hold, and the date check.
    initial begin
        int        wait_cycles;
        t_cal_date want;
        t_cal_date got;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wait_cycles = (dates_checked == HOLD_RESULT) ? HOLD_CYCLES
                                                         : draw_gap(dates_checked + 16);
            if (wait_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
            got.year  = o_m_axis_tdata[10:0];
            got.month = o_m_axis_tdata[14:11];
            got.day   = o_m_axis_tdata[19:15];
            if (expected_dates.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transfer, date %0d-%0d-%0d", $time,
                         got.year, got.month, got.day);
            end else begin
                want = expected_dates.pop_front();
                if (got.year !== want.year) begin
                    mismatches++;
                    $display("%0t: year expected %0d actual %0d", $time,
                             want.year, got.year);
                end
                if (got.month !== want.month) begin
                    mismatches++;
                    $display("%0t: month expected %0d actual %0d", $time,
                             want.month, got.month);
                end
                if (got.day !== want.day) begin
                    mismatches++;
                    $display("%0t: day expected %0d actual %0d", $time,
                             want.day, got.day);
                end
            end
            if (got.month == 4'd2 && got.day == 5'd29) begin
                leap_days_seen++;
            end
            if (int'(got.year) > newest_year) begin
                newest_year = int'(got.year);
            end
            dates_checked++;
        end
    end

    // Watchdog: cycles with no transfer on either side.
    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL epoch_seconds_to_date");
        $finish;
    end

    initial begin
        t_cal_date blank;
        blank = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[r]) begin
            send_seconds(directed_rows[r].secs, directed_rows[r].typed,
                         '{directed_rows[r].year, directed_rows[r].month,
                           directed_rows[r].day});
        end
        repeat (RANDOM_ITEMS) begin
            send_seconds(random_seconds(), 1'b0, blank);
        end
        i_s_axis_tvalid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Converted %0d second counts (%0d directed), %0d dates checked,",
                 items_sent, DIRECTED_ROWS, dates_checked);
        $display("%0d of them Feb 29, latest year %0d, %0d mismatches",
                 leap_days_seen, newest_year, mismatches);
        if (mismatches == 0 && expected_dates.size() == 0) begin
            $display("PASS epoch_seconds_to_date");
        end else begin
            $display("FAIL epoch_seconds_to_date");
        end
        $finish;
    end

endmodule
